/* src/config_image_crc_validator_defines.svh */
// ----------------------------------------------------------------------------
// Settings image validator assertion macros
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef CONFIG_IMAGE_CRC_VALIDATOR_DEFINES_SVH
`define CONFIG_IMAGE_CRC_VALIDATOR_DEFINES_SVH

// assertion sampled on the clock, masked while reset is low
`define CICV_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion sampled on the clock, active during reset as well
`define CICV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/cicv_pkg.sv */
// ----------------------------------------------------------------------------
// Settings image validator package
// Shared constants and codes for the image check.
// ----------------------------------------------------------------------------
package cicv_pkg;

    localparam int NAME_CHARS   = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [7:0]  MAGIC_BYTE = 8'hBE;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_GOOD   = 16'h1D0F;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] MIN_RECORD = 16'd6;
    localparam logic [15:0] REGION_RST = 16'd4096;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_EXP_VERSION = 2'd0;
    localparam t_cfg_index CFG_BOARD_NAME  = 2'd1;
    localparam t_cfg_index CFG_REGION      = 2'd2;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_VERSION = 3'd1,
        ERR_MAGIC   = 3'd2,
        ERR_NAME    = 3'd3,
        ERR_SIZE    = 3'd4,
        ERR_CRC     = 3'd5
    } t_err_code;

endpackage

/* src/cicv_req_if.sv */
// ----------------------------------------------------------------------------
// Settings image validator request channel
// Valid/ready channel that carries one image byte per request.
// ----------------------------------------------------------------------------
interface cicv_req_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, data_byte, first_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, output ready);

endinterface

/* src/cicv_rsp_if.sv */
// ----------------------------------------------------------------------------
// Settings image validator verdict channel
// Valid/ready channel that carries one verdict per scan.
// ----------------------------------------------------------------------------
interface cicv_rsp_if;

    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [2:0]  error_code;
    logic [15:0] image_size;
    logic [15:0] crc_residue;

    modport source (output valid, valid_res, error_code, image_size, crc_residue,
                    input ready);
    modport sink   (input valid, valid_res, error_code, image_size, crc_residue,
                    output ready);

endinterface

/* src/cicv_crc_byte.sv */
// ----------------------------------------------------------------------------
// Settings image validator CRC byte update
// CRC-16/CCITT-FALSE next value for one byte, MSB first.
// ----------------------------------------------------------------------------
module cicv_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);
    import cicv_pkg::*;

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

/* src/config_image_crc_validator.sv */
// ----------------------------------------------------------------------------
// Settings image validator
// Scans a stored settings image one byte per request and gives one verdict.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle unless stalled. Each byte passes the
// byte-wide CRC update and the header, record-size and footer checks, and a
// verdict appears on the verdict channel in the cycle after the byte that
// closes the scan (a failing header byte, a bad high size byte, or the second
// stored CRC byte). Ready drops only while a verdict is held and the verdict
// sink stalls. A byte marked first restarts the scan at once; bytes that
// arrive after a verdict without the first mark are dropped. Configuration
// is written by the user via the plain write port while idle; not enforced.
module config_image_crc_validator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  cicv_pkg::t_cfg_index         i_cfg_index,
    input  logic [cicv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cicv_req_if.sink                     i_req,
    cicv_rsp_if.source                   o_rsp
);
    import cicv_pkg::*;

    typedef enum logic [2:0] {
        PH_FINISHED = 3'd0,
        PH_HEADER   = 3'd1,
        PH_SIZE_LO  = 3'd2,
        PH_SIZE_HI  = 3'd3,
        PH_BODY     = 3'd4,
        PH_CRC_HI   = 3'd5,
        PH_CRC_LO   = 3'd6
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_offset,    n_offset;
    logic [15:0] r_crc,       n_crc;
    logic [15:0] r_rec_end,   n_rec_end;
    logic [7:0]  r_size_lo,   n_size_lo;
    logic [7:0]  r_exp_ver;
    logic [31:0] r_board_name;
    logic [15:0] r_region;
    logic        r_out_valid, n_out_valid;
    logic        r_res_ok,    n_res_ok;
    t_err_code   r_err,       n_err;
    logic [15:0] r_img_size,  n_img_size;
    logic [15:0] r_residue,   n_residue;

    logic        accept;
    logic        res_fire;
    logic [15:0] crc_in;
    logic [15:0] crc_new;

    function automatic logic [7:0] name_char(input logic [31:0] name,
                                             input logic [15:0] idx);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < 4; k++) begin
            if (k < NAME_CHARS && idx == 16'(k)) begin
                c = name[8*k +: 8];
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign crc_in      = i_req.first_byte ? CRC_INIT : r_crc;

    cicv_crc_byte u_crc (
        .i_crc  (crc_in),
        .i_data (i_req.data_byte),
        .o_crc  (crc_new)
    );

    always_comb begin
        t_phase      cur_phase;
        logic [15:0] pos;
        logic [15:0] name_idx;
        logic        ended;
        logic [15:0] size16;
        logic [15:0] start;
        logic [16:0] rec_sum;
        logic [7:0]  b;
        t_err_code   code;
        logic [15:0] total;

        n_phase    = r_phase;
        n_offset   = r_offset;
        n_crc      = r_crc;
        n_rec_end  = r_rec_end;
        n_size_lo  = r_size_lo;
        res_fire   = 1'b0;
        code       = ERR_NONE;
        total      = 16'h0000;
        b          = i_req.data_byte;
        cur_phase  = i_req.first_byte ? PH_HEADER : r_phase;
        pos        = i_req.first_byte ? 16'h0000 : r_offset;
        name_idx   = pos - 16'd2;
        size16     = {b, r_size_lo};
        start      = pos - 16'd1;
        rec_sum    = {1'b0, start} + {1'b0, size16};
        ended      = 1'b0;
        for (int j = 0; j < NAME_CHARS; j++) begin
            if (16'(j) < name_idx && name_char(r_board_name, 16'(j)) == 8'h00) begin
                ended = 1'b1;
            end
        end

        if (accept && (i_req.first_byte || r_phase != PH_FINISHED)) begin
            n_phase  = cur_phase;
            n_crc    = crc_new;
            n_offset = (pos == 16'hFFFF) ? pos : pos + 16'd1;
            if (i_req.first_byte) begin
                n_rec_end = 16'h0000;
                n_size_lo = 8'h00;
            end
            unique case (cur_phase)
                PH_HEADER: begin
                    if (pos == 16'd0) begin
                        if (b != r_exp_ver) begin
                            res_fire = 1'b1;
                            code     = ERR_VERSION;
                        end
                    end else if (pos == 16'd1) begin
                        if (b != MAGIC_BYTE) begin
                            res_fire = 1'b1;
                            code     = ERR_MAGIC;
                        end
                    end else begin
                        if (!ended && to_lower(b) !=
                                to_lower(name_char(r_board_name, name_idx))) begin
                            res_fire = 1'b1;
                            code     = ERR_NAME;
                        end else if (name_idx >= 16'(NAME_CHARS)) begin
                            n_phase = PH_SIZE_LO;
                        end
                    end
                end
                PH_SIZE_LO: begin
                    n_size_lo = b;
                    n_phase   = PH_SIZE_HI;
                end
                PH_SIZE_HI: begin
                    if (size16 == 16'h0000) begin
                        n_phase = PH_CRC_HI;
                    end else if (size16 < MIN_RECORD || rec_sum >= {1'b0, r_region}) begin
                        res_fire = 1'b1;
                        code     = ERR_SIZE;
                    end else begin
                        n_rec_end = rec_sum[15:0];
                        n_phase   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if ({1'b0, pos} + 17'd1 >= {1'b0, r_rec_end}) begin
                        n_phase = PH_SIZE_LO;
                    end
                end
                PH_CRC_HI: begin
                    n_phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    res_fire = 1'b1;
                    code     = (crc_new == CRC_GOOD) ? ERR_NONE : ERR_CRC;
                    total    = (pos == 16'hFFFF) ? pos : pos + 16'd1;
                end
                default: begin
                    n_phase = PH_FINISHED;
                end
            endcase
            if (res_fire) begin
                n_phase = PH_FINISHED;
            end
        end

        n_out_valid = r_out_valid;
        n_res_ok    = r_res_ok;
        n_err       = r_err;
        n_img_size  = r_img_size;
        n_residue   = r_residue;
        if (res_fire) begin
            n_out_valid = 1'b1;
            n_res_ok    = (code == ERR_NONE);
            n_err       = code;
            n_img_size  = (code == ERR_NONE) ? total : 16'h0000;
            n_residue   = crc_new;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FINISHED;
            r_offset     <= 16'h0000;
            r_crc        <= CRC_INIT;
            r_rec_end    <= 16'h0000;
            r_size_lo    <= 8'h00;
            r_exp_ver    <= 8'h00;
            r_board_name <= 32'h0000_0000;
            r_region     <= REGION_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_crc       <= n_crc;
            r_rec_end   <= n_rec_end;
            r_size_lo   <= n_size_lo;
            r_out_valid <= n_out_valid;
            r_res_ok    <= n_res_ok;
            r_err       <= n_err;
            r_img_size  <= n_img_size;
            r_residue   <= n_residue;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_EXP_VERSION: r_exp_ver    <= i_cfg_data[7:0];
                    CFG_BOARD_NAME:  r_board_name <= i_cfg_data[31:0];
                    CFG_REGION:      r_region     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.valid_res   = r_res_ok;
    assign o_rsp.error_code  = r_err;
    assign o_rsp.image_size  = r_img_size;
    assign o_rsp.crc_residue = r_residue;

endmodule

/* src/cicv_checker.sv */
// ----------------------------------------------------------------------------
// Settings image validator checker
// Port-level checks on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "config_image_crc_validator_defines.svh"

module cicv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic        i_rsp_valid_res,
    input  logic [2:0]  i_rsp_error_code,
    input  logic [15:0] i_rsp_image_size,
    input  logic [15:0] i_rsp_crc_residue
);
    import cicv_pkg::*;

    `CICV_ASSERT_ALWAYS(a_no_verdict_after_reset, $past(!i_rst_n) |-> !i_rsp_valid, "verdict right after reset")
    `CICV_ASSERT_RST(a_hold_stalled, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_error_code) && $stable(i_rsp_image_size) && $stable(i_rsp_crc_residue)), "stalled verdict changed")
    `CICV_ASSERT_RST(a_ok_matches_code, i_rsp_valid |-> (i_rsp_valid_res == (i_rsp_error_code == ERR_NONE)), "pass flag disagrees with code")
    `CICV_ASSERT_RST(a_error_no_size, (i_rsp_valid && i_rsp_error_code != ERR_NONE) |-> (i_rsp_image_size == 16'h0000), "size reported on failing scan")
    `CICV_ASSERT_RST(a_pass_residue, (i_rsp_valid && i_rsp_valid_res) |-> (i_rsp_crc_residue == CRC_GOOD), "pass with wrong residue")

endmodule

bind config_image_crc_validator cicv_checker u_cicv_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_valid_res   (o_rsp.valid_res),
    .i_rsp_error_code  (o_rsp.error_code),
    .i_rsp_image_size  (o_rsp.image_size),
    .i_rsp_crc_residue (o_rsp.crc_residue)
);
